>>> src/cbst_pkg.sv
// cbst_pkg: shared types and constants for the cell burn switch test block
// no dependencies; imported by every module of the block

package cbst_pkg;

   // cell geometry
   localparam int NODES_PER_CELL = 8;
   localparam int NODE_CNT_W     = $clog2(NODES_PER_CELL);

   // field widths
   localparam int WEIGHT_W   = 16;
   localparam int MASS_W     = 32;
   localparam int TEMP_W     = 24;
   localparam int PROD_W     = WEIGHT_W + MASS_W;
   localparam int FRAC_SHIFT = 14;
   localparam int TM_W       = TEMP_W + MASS_W;
   localparam int MSUM_W     = MASS_W + NODE_CNT_W;
   localparam int TMSUM_W    = TM_W + NODE_CNT_W;
   localparam int THR_PROD_W = TEMP_W + MSUM_W;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_TEMP   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_MASS_FLOOR   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_MASS_CEILING = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DENSITY_FLOOR    = 2'd3;

   // node queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // one classified node, as it travels from front to back
   typedef struct packed {
      logic [MASS_W-1:0] wmass;
      logic [TEMP_W-1:0] temp;
      logic              new_pass;
   } node_type;

   // configuration registers as seen by the back end
   typedef struct packed {
      logic [TEMP_W-1:0] threshold_temp;
      logic [MASS_W-1:0] max_mass_floor;
      logic [MASS_W-1:0] min_mass_ceiling;
      logic [MASS_W-1:0] density_floor;
   } cfg_type;

endpackage

>>> src/cbst_req_if.sv
// cbst_req_if: valid/ready channel carrying one grid node word
// depends on cbst_pkg for field widths

interface cbst_req_if
   import cbst_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [WEIGHT_W-1:0] node_weight;
   logic [MASS_W-1:0]   node_mass;
   logic [TEMP_W-1:0]   node_temp;
   logic                new_pass;

   modport source (output valid, node_weight, node_mass, node_temp, new_pass,
                   input ready);
   modport sink   (input valid, node_weight, node_mass, node_temp, new_pass,
                   output ready);
endinterface

>>> src/cbst_rsp_if.sv
// cbst_rsp_if: valid/ready channel carrying one cell result word
// no package dependencies

interface cbst_rsp_if;
   logic valid;
   logic ready;
   logic cell_meets;
   logic switch_seen;

   modport source (output valid, cell_meets, switch_seen, input ready);
   modport sink   (input valid, cell_meets, switch_seen, output ready);
endinterface

>>> src/cbst_front.sv
// cbst_front: accepts node words and forms the saturated weighted mass
// depends on cbst_pkg and cbst_req_if; feeds cbst_queue

module cbst_front
   import cbst_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   cbst_req_if.sink    req_if,
   output logic        push_valid,
   input  logic        push_ready,
   output node_type    push_node
);

   logic                fr_valid_ff, fr_valid_in;
   node_type            fr_node_ff;
   logic [PROD_W-1:0]   prod;
   logic [PROD_W-FRAC_SHIFT-1:0] prod_sh;
   logic [MASS_W-1:0]   wmass;
   logic                accept;

   // weighted mass, q2.14 times q16.16 back to q16.16, saturating
   always_comb begin
      prod    = PROD_W'(req_if.node_weight) * PROD_W'(req_if.node_mass);
      prod_sh = prod[PROD_W-1:FRAC_SHIFT];
      if (|prod_sh[PROD_W-FRAC_SHIFT-1:MASS_W]) begin
         wmass = '1;
      end else begin
         wmass = prod_sh[MASS_W-1:0];
      end
   end

   // stage holds one word until the queue takes it
   assign req_if.ready = !fr_valid_ff || push_ready;
   assign accept       = req_if.valid && req_if.ready;

   always_comb begin
      fr_valid_in = fr_valid_ff;
      if (accept) begin
         fr_valid_in = 1'b1;
      end else if (push_ready) begin
         fr_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff <= 1'b0;
      end else begin
         fr_valid_ff <= fr_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fr_node_ff.wmass    <= wmass;
         fr_node_ff.temp     <= req_if.node_temp;
         fr_node_ff.new_pass <= req_if.new_pass;
      end
   end

   assign push_valid = fr_valid_ff;
   assign push_node  = fr_node_ff;

endmodule

>>> src/cbst_queue.sv
// cbst_queue: short register queue of classified nodes between front and back
// depends on cbst_pkg

module cbst_queue
   import cbst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_ready,
   input  node_type push_node,
   output logic     pop_valid,
   input  logic     pop_ready,
   output node_type pop_node
);

   node_type            entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign push_ready = count_ff != QCNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_node   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_node;
      end
   end

endmodule

>>> src/cbst_back.sv
// cbst_back: per-node accumulation, end-of-cell criterion and result register
// depends on cbst_pkg and cbst_rsp_if; fed by cbst_queue

module cbst_back
   import cbst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  node_type   pop_node,
   cbst_rsp_if.source rsp_if
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_MUL  = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_CHK  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   node_type               cur_ff;
   logic [TM_W-1:0]        tm_ff;
   logic [NODE_CNT_W-1:0]  count_ff, count_in;
   logic [MSUM_W-1:0]      msum_ff;
   logic [TMSUM_W-1:0]     tmsum_ff;
   logic [MASS_W-1:0]      max_ff, min_ff;
   logic [THR_PROD_W-1:0]  thr_prod_ff;
   logic                   flag_ff, flag_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic                   rsp_meets_ff, rsp_seen_ff;

   logic [MSUM_W-1:0]      msum_base;
   logic [TMSUM_W-1:0]     tmsum_base;
   logic [MASS_W-1:0]      max_base, min_base;
   logic                   cell_start, last_node;
   logic                   out_free, load_out;
   logic [MASS_W+2:0]      min_x5, max_x3;
   logic                   meets;

   assign cell_start = count_ff == '0;
   assign last_node  = count_ff == NODE_CNT_W'(NODES_PER_CELL - 1);
   assign pop_ready  = state_ff == ST_IDLE;
   assign out_free   = !rsp_valid_ff || rsp_if.ready;
   assign load_out   = (state_ff == ST_DONE) && out_free;

   // starting values at the first node of a cell
   always_comb begin
      if (cell_start) begin
         max_base   = cfg.max_mass_floor;
         min_base   = cfg.min_mass_ceiling;
         msum_base  = '0;
         tmsum_base = '0;
      end else begin
         max_base   = max_ff;
         min_base   = min_ff;
         msum_base  = msum_ff;
         tmsum_base = tmsum_ff;
      end
   end

   // criterion: 5*min < 3*max, min > 0, max > density floor, temp sum >= thr * mass sum
   always_comb begin
      min_x5 = (MASS_W+3)'({min_ff, 2'b00}) + (MASS_W+3)'(min_ff);
      max_x3 = (MASS_W+3)'({max_ff, 1'b0}) + (MASS_W+3)'(max_ff);
      meets  = (min_x5 < max_x3) && (min_ff != '0) && (max_ff > cfg.density_floor)
               && (tmsum_ff >= thr_prod_ff);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      flag_in  = flag_ff;
      case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (cur_ff.new_pass) begin
               flag_in = 1'b0;
            end
            if (last_node) begin
               count_in = '0;
               state_in = ST_CHK;
            end else begin
               count_in = count_ff + 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_CHK: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               flag_in  = flag_ff || meets;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         flag_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         flag_ff      <= flag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && pop_valid) begin
         cur_ff <= pop_node;
      end
      if (state_ff == ST_MUL) begin
         tm_ff <= TM_W'(cur_ff.temp) * TM_W'(cur_ff.wmass);
      end
      if (state_ff == ST_ACC) begin
         max_ff   <= (cur_ff.wmass > max_base) ? cur_ff.wmass : max_base;
         min_ff   <= (cur_ff.wmass < min_base) ? cur_ff.wmass : min_base;
         msum_ff  <= msum_base + MSUM_W'(cur_ff.wmass);
         tmsum_ff <= tmsum_base + TMSUM_W'(tm_ff);
      end
      if (state_ff == ST_CHK) begin
         thr_prod_ff <= THR_PROD_W'(cfg.threshold_temp) * THR_PROD_W'(msum_ff);
      end
      if (load_out) begin
         rsp_meets_ff <= meets;
         rsp_seen_ff  <= flag_ff || meets;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.cell_meets  = rsp_meets_ff;
   assign rsp_if.switch_seen = rsp_seen_ff;

endmodule

>>> src/cell_burn_switch_test.sv
// Cell burn switch test. Grid nodes arrive one word at a time; every eight
// nodes form a cell, and after the eighth node one result word reports whether
// the cell meets the burn criterion together with the sticky pass flag. The
// front stage takes one node per cycle while the queue has room, forms the
// saturated weighted mass and hands it to a four-entry queue. The back
// sequencer takes each node through dequeue, temperature multiply and
// accumulate; the last node of a cell adds a threshold multiply and the
// compare and load of the result register. It takes no new node before the
// last one is through. Registers must be written only while the block is
// idle; the block itself does not enforce this. Floor and ceiling take effect at the next cell start.
//
// depends on cbst_pkg, cbst_req_if, cbst_rsp_if, cbst_front, cbst_queue, cbst_back

module cell_burn_switch_test
   import cbst_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   cbst_req_if.sink              req_if,
   cbst_rsp_if.source            rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg_ff;
   logic     push_valid, push_ready;
   node_type push_node;
   logic     pop_valid, pop_ready;
   node_type pop_node;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.threshold_temp   <= '0;
         cfg_ff.max_mass_floor   <= '0;
         cfg_ff.min_mass_ceiling <= '1;
         cfg_ff.density_floor    <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_THRESHOLD_TEMP:   cfg_ff.threshold_temp   <= csr_wdata[TEMP_W-1:0];
            CSR_MAX_MASS_FLOOR:   cfg_ff.max_mass_floor   <= csr_wdata[MASS_W-1:0];
            CSR_MIN_MASS_CEILING: cfg_ff.min_mass_ceiling <= csr_wdata[MASS_W-1:0];
            CSR_DENSITY_FLOOR:    cfg_ff.density_floor    <= csr_wdata[MASS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // node intake and weighted mass
   cbst_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_node  (push_node)
   );

   // decoupling queue
   cbst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_node  (push_node),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_node   (pop_node)
   );

   // accumulation and cell criterion
   cbst_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_node  (pop_node),
      .rsp_if    (rsp_if)
   );

endmodule
